// ===== rtl/fmt_pkg.sv =====
// ----------------------------------------------------------------------------
// fmt_pkg: shared types and constants for the truncating fp32 multiplier
// Field widths, bias and the per-cell payload record.
// ----------------------------------------------------------------------------
package fmt_pkg;
    localparam int unsigned FRAC_W = 23;
    localparam int unsigned SIG_W  = 24;
    localparam int unsigned PROD_W = 48;
    localparam int unsigned EXP_W  = 8;
    localparam int unsigned WORD_W = 32;
    // exponent carried with two guard bits: range -127..383 plus carry
    localparam int unsigned EXPS_W = 10;
    localparam logic signed [EXPS_W-1:0] BIAS = 10'sd127;
    localparam logic signed [EXPS_W-1:0] EXP_MAX = 10'sd255;
    localparam int unsigned CHUNK_W = 8;
    localparam int unsigned N_CELLS = SIG_W / CHUNK_W;

    typedef struct packed {
        logic                     vld;
        logic                     sign;
        logic signed [EXPS_W-1:0] exp;
        logic [SIG_W-1:0]         sig_a;
        logic [SIG_W-1:0]         sig_b;
        logic [PROD_W-1:0]        acc;
    } t_cell;
endpackage

// ===== rtl/fp32_multiply_truncating_unit.sv =====
// ----------------------------------------------------------------------------
// fp32_multiply_truncating_unit: truncating single-precision multiplier
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_operand_a / i_operand_b and raise start; a transaction is taken
//   at every edge where start is high and busy is low. busy is never high,
//   so one operand pair can enter each cycle.
//   Stages from the accepting edge to the result strobe:
//   one input register, three multiply cells (8 bits of B each), one
//   normalize/output register. Throughput: one transaction per cycle.
//   o_result holds sign, low 8 exponent bits and the truncated 23-bit
//   fraction; o_exp_out_of_range flags a final exponent outside 0..255.
//   o_valid marks the result for exactly one cycle; the receiver cannot
//   stall, so results are never held back.
//   Synchronous active-low reset clears all valid bits in the chain; any
//   transaction in flight is dropped.
// ----------------------------------------------------------------------------
module fp32_multiply_truncating_unit
    import fmt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [WORD_W-1:0] i_operand_a,
    input  logic [WORD_W-1:0] i_operand_b,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_result,
    output logic              o_exp_out_of_range
);
    t_cell r_in;
    t_cell w_chain [N_CELLS+1];
    logic              r_valid;
    logic [WORD_W-1:0] r_result;
    logic              r_oor;
    logic signed [EXPS_W-1:0] w_exp;
    logic [FRAC_W-1:0] w_frac;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
        end else begin
            r_in.vld <= start && !busy;
        end
        r_in.sign  <= i_operand_a[WORD_W-1] ^ i_operand_b[WORD_W-1];
        r_in.exp   <= $signed({2'b00, i_operand_a[FRAC_W +: EXP_W]})
                    + $signed({2'b00, i_operand_b[FRAC_W +: EXP_W]}) - BIAS;
        r_in.sig_a <= {1'b1, i_operand_a[FRAC_W-1:0]};
        r_in.sig_b <= {1'b1, i_operand_b[FRAC_W-1:0]};
        r_in.acc   <= '0;
    end

    assign w_chain[0] = r_in;

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        fmt_cell #(.IDX(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cell (w_chain[g]),
            .o_cell (w_chain[g+1])
        );
    end

    always_comb begin
        w_exp  = w_chain[N_CELLS].exp;
        w_frac = w_chain[N_CELLS].acc[FRAC_W +: FRAC_W];
        if (w_chain[N_CELLS].acc[PROD_W-1]) begin
            w_exp  = w_chain[N_CELLS].exp + 10'sd1;
            w_frac = w_chain[N_CELLS].acc[SIG_W +: FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_chain[N_CELLS].vld;
        end
        r_result <= {w_chain[N_CELLS].sign, w_exp[EXP_W-1:0], w_frac};
        r_oor    <= (w_exp < 0) || (w_exp > EXP_MAX);
    end

    assign o_valid            = r_valid;
    assign o_result           = r_result;
    assign o_exp_out_of_range = r_oor;
endmodule

// ===== rtl/fmt_cell.sv =====
// ----------------------------------------------------------------------------
// fmt_cell: one multiply step
// Adds significand A times one 8-bit slice of significand B into the
// running product and hands the record on to the next cell.
// ----------------------------------------------------------------------------
module fmt_cell
    import fmt_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cell i_cell,
    output t_cell o_cell
);
    t_cell r_cell;
    t_cell n_cell;
    logic [SIG_W+CHUNK_W-1:0] w_part;

    always_comb begin
        w_part = i_cell.sig_a * i_cell.sig_b[IDX*CHUNK_W +: CHUNK_W];
        n_cell = i_cell;
        n_cell.acc = i_cell.acc +
            (PROD_W'(w_part) << (IDX*CHUNK_W));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else begin
            r_cell.vld <= n_cell.vld;
        end
        r_cell.sign  <= n_cell.sign;
        r_cell.exp   <= n_cell.exp;
        r_cell.sig_a <= n_cell.sig_a;
        r_cell.sig_b <= n_cell.sig_b;
        r_cell.acc   <= n_cell.acc;
    end

    assign o_cell = r_cell;
endmodule

// ===== rtl/fmt_checker.sv =====
// ----------------------------------------------------------------------------
// fmt_checker: port-level checks for the fp32 multiplier
// Never-busy, latency, spurious-result and sign consistency seen at the ports.
// ----------------------------------------------------------------------------
module fmt_checker
    import fmt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [WORD_W-1:0] i_operand_a,
    input logic [WORD_W-1:0] i_operand_b,
    input logic              o_valid,
    input logic [WORD_W-1:0] o_result,
    input logic              o_exp_out_of_range
);
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy asserted");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid) else $error("result missing");

    a_no_spurious: assert property (@(posedge i_clk)
        disable iff (!i_rst_n || !$past(i_rst_n, 5))
        o_valid |-> $past(start && !busy, 5)) else $error("spurious result");

    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5
        (o_result[WORD_W-1] == $past(i_operand_a[WORD_W-1] ^ i_operand_b[WORD_W-1], 5)))
        else $error("sign mismatch");
endmodule

bind fp32_multiply_truncating_unit fmt_checker u_fmt_checker (.*);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: fp32_multiply_truncating_unit check
// Drives operand pairs through the start/busy handshake and compares every
// strobed product against a local truncating multiply model, in order.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fmt_pkg::*;

    localparam int LIMIT = 400000;
    localparam int DRAIN = 12;

    typedef struct {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        bit                has_exp;
        logic [WORD_W-1:0] res;
        logic              oor;
    } vec_t;

    typedef struct {
        logic [WORD_W-1:0] res;
        logic              oor;
    } prod_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [WORD_W-1:0] i_operand_a = '0;
    logic [WORD_W-1:0] i_operand_b = '0;
    logic              o_valid;
    logic [WORD_W-1:0] o_result;
    logic              o_exp_out_of_range;

    prod_t pending_products[$];
    int    n_errors = 0;
    int    cycle = 0;
    int    idle_pct = 0;

    fp32_multiply_truncating_unit uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("fp32_multiply_truncating_unit test failed");
            $finish;
        end
    end

    function automatic prod_t mul_trunc(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
        prod_t p;
        logic [PROD_W-1:0] m;
        logic [FRAC_W-1:0] frac;
        int e;
        m = {24'd0, 1'b1, a[FRAC_W-1:0]} * {24'd0, 1'b1, b[FRAC_W-1:0]};
        e = int'(a[30:23]) + int'(b[30:23]) - 127;
        if (m[PROD_W-1]) begin
            e++;
            frac = m[46:24];
        end else begin
            frac = m[45:23];
        end
        p.oor = (e < 0) || (e > 255);
        p.res = {a[31] ^ b[31], e[7:0], frac};
        return p;
    endfunction

    task automatic report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
        n_errors++;
        if (n_errors <= 40)
            $display("mismatch %s at cycle %0d: got %h want %h", what, cycle, got, want);
    endtask

    // result monitor: sample in the clock's own step, after outputs settled
    always @(posedge i_clk) begin
        prod_t w;
        if (i_rst_n && o_valid) begin
            if (pending_products.size() == 0) begin
                report("unexpected product", o_result, '0);
            end else begin
                w = pending_products.pop_front();
                if (o_result !== w.res) report("result", o_result, w.res);
                if (o_exp_out_of_range !== w.oor)
                    report("exp_out_of_range", o_exp_out_of_range, w.oor);
            end
        end
    end

    // one transaction; start stays high across back-to-back items
    task automatic issue(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_products.push_back(mul_trunc(a, b));
    endtask

    function automatic logic [WORD_W-1:0] rnd_word();
        case ($urandom_range(5))
            0: return {1'($urandom_range(1)), 8'hFF, 23'($urandom)};
            1: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
            2: return {1'($urandom_range(1)), 8'($urandom_range(100, 160)), 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    vec_t directed[$] = '{
        '{32'h3F800000, 32'h3F800000, 1, 32'h3F800000, 1'b0}, // 1.0 * 1.0
        '{32'h3F800000, 32'hBF800000, 1, 32'hBF800000, 1'b0}, // sign only
        '{32'h40000000, 32'h40000000, 1, 32'h40800000, 1'b0},
        '{32'h00000000, 32'h00000000, 1, 32'h40800000, 1'b1}, // zero: hidden one kept
        '{32'h7F800000, 32'h7F800000, 1, 32'h3F800000, 1'b1}, // overflow wrap
        '{32'hFFFFFFFF, 32'hFFFFFFFF, 0, '0, 1'b0},
        '{32'h3FFFFFFF, 32'h3FFFFFFF, 0, '0, 1'b0},            // carry into bit 47
        '{32'h00000000, 32'h3F000000, 1, 32'h7F800000, 1'b1},
        '{32'h00000000, 32'h3E800000, 1, 32'h7F000000, 1'b1}, // underflow wrap
        '{32'h7F000000, 32'h40000000, 1, 32'h7F800000, 1'b0}, // exponent 255
        '{32'h7F000000, 32'h40800000, 1, 32'h00000000, 1'b1}, // exponent 256
        '{32'h007FFFFF, 32'h807FFFFF, 0, '0, 1'b0},            // denormals
        '{32'h7FC00001, 32'h3F800000, 0, '0, 1'b0},            // NaN
        '{32'hAAAAAAAA, 32'h55555555, 0, '0, 1'b0},
        '{32'h55555555, 32'hAAAAAAAA, 0, '0, 1'b0}
    };

    initial begin
        prod_t p;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) begin
            if (directed[k].has_exp) begin
                p = mul_trunc(directed[k].a, directed[k].b);
                if (p.res !== directed[k].res || p.oor !== directed[k].oor)
                    report("directed table", p.res, directed[k].res);
            end
            issue(directed[k].a, directed[k].b);
        end
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 83 : (ph == 3) ? 13 : 0;
            for (int k = 0; k < 270; k++) begin
                if (k == 135 && ph == 1) begin
                    start <= 1'b0;
                    @(posedge i_clk);
                    while (pending_products.size() != 0) @(posedge i_clk);
                end
                issue(rnd_word(), rnd_word());
            end
        end
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_products.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (n_errors == 0)
            $display("fp32_multiply_truncating_unit test passed");
        else
            $display("fp32_multiply_truncating_unit test failed");
        $finish;
    end
endmodule
